@@ rtl/eeprom_transfer_segmenter_unit_defines.svh @@
// Assertion macros used by the segmenter top level
`ifndef EEPROM_TRANSFER_SEGMENTER_UNIT_DEFINES_SVH
`define EEPROM_TRANSFER_SEGMENTER_UNIT_DEFINES_SVH

// antecedent true implies consequent in the same cycle
`define ETS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segmenter check failed");

// antecedent true implies consequent in the next cycle
`define ETS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segmenter check failed");

`endif

@@ rtl/ets_pkg.sv @@
// Types, constants and helper functions of the EEPROM transfer segmenter
package ets_pkg;

  localparam int MAX_LENGTH = 256;
  localparam int LEN_W      = 9;
  localparam int ADDR_W     = 16;

  localparam logic [1:0] REG_MEM_SIZE_LOG2  = 2'd0;
  localparam logic [1:0] REG_PAGE_SIZE_LOG2 = 2'd1;
  localparam logic [1:0] REG_TWO_BYTE_ADDR  = 2'd2;
  localparam logic [1:0] REG_BASE_DEV_ADDR  = 2'd3;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  length;
  } ets_req_t;

  typedef struct packed {
    logic [7:0]        device_address;
    logic [ADDR_W-1:0] word_address;
    logic [LEN_W-1:0]  byte_count;
    logic [7:0]        buffer_offset;
    logic              last_segment;
  } ets_res_t;

  // operands of the segment step unit
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  done;
    logic [LEN_W-1:0]  len;
    logic [7:0]        mask;
    logic              whole;
  } ets_step_in_t;

  typedef struct packed {
    logic [LEN_W-1:0]  cnt;
    logic [LEN_W-1:0]  done_next;
    logic [ADDR_W-1:0] addr_next;
    logic              last;
  } ets_step_out_t;

  function automatic logic [1:0] bank_bits(input logic [4:0] msl, input logic two_byte);
    logic [4:0] m;
    m = msl;
    if (m < 5'd7)  m = 5'd7;
    if (m > 5'd16) m = 5'd16;
    if (two_byte || m <= 5'd8) begin
      return 2'd0;
    end else if (m >= 5'd11) begin
      return 2'd3;
    end else begin
      return 2'(m - 5'd8);
    end
  endfunction

  function automatic logic [7:0] page_mask(input logic [2:0] psl);
    logic [2:0] pl;
    pl = (psl < 3'd3) ? 3'd3 : psl;
    return 8'((9'd1 << pl) - 9'd1);
  endfunction

  function automatic logic [7:0] device_byte(input logic [7:0] base, input logic [1:0] bits,
                                             input logic [ADDR_W-1:0] addr);
    logic [2:0] lowmask;
    logic [2:0] upper;
    lowmask = 3'((4'd1 << bits) - 4'd1);
    upper   = addr[10:8] & lowmask;
    return (base & ~{4'd0, lowmask, 1'b0}) | {4'd0, upper, 1'b0};
  endfunction

  function automatic logic [LEN_W-1:0] sat_length(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len;
  endfunction

endpackage

@@ rtl/ets_step.sv @@
// Combinational segment step unit: byte count, last flag, next done count and next address for one segment
module ets_step (
  input  ets_pkg::ets_step_in_t  op,
  output ets_pkg::ets_step_out_t res
);
  import ets_pkg::*;

  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] rest;
  logic [LEN_W-1:0] cnt;

  always_comb begin
    room = ({1'b0, op.mask} + 9'd1) - {1'b0, op.addr[7:0] & op.mask};
    rest = op.len - op.done;
    if (op.whole || rest < room) begin
      cnt = rest;
    end else begin
      cnt = room;
    end
    res.cnt       = cnt;
    res.done_next = op.done + cnt;
    res.last      = (op.done + cnt) >= op.len;
    res.addr_next = op.addr + {{(ADDR_W-LEN_W){1'b0}}, cnt};
  end

endmodule

@@ rtl/eeprom_transfer_segmenter_unit.sv @@
// Top level of the EEPROM transfer segmenter: registers, sequencer and result register
// A request is taken when start is high and busy is low; it then emits one segment
// per clock on result with strobe high, the final one flagged by last_segment, and
// busy stays high until that final segment is issued. The single step unit works out
// one segment per cycle. Zero-length writes, and zero-length reads on a banked chip,
// produce no beat. Results cannot be stalled: the receiver must take every beat in the
// cycle it is shown. Registers must be written only while busy is low; the block itself
// does not enforce this.
module eeprom_transfer_segmenter_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ets_pkg::ets_req_t request,
  output logic             busy,
  output logic             strobe,
  output ets_pkg::ets_res_t result,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);
  import ets_pkg::*;

  `include "eeprom_transfer_segmenter_unit_defines.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [4:0] memory_size_log2;
  logic [2:0] page_size_log2;
  logic       two_byte_word_address;
  logic [7:0] base_device_address;

  logic              state;
  logic              state_next;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  done;
  logic [LEN_W-1:0]  len;
  logic [7:0]        mask;
  logic              whole;
  logic [1:0]        bits;

  ets_step_in_t  step_in;
  ets_step_out_t step_out;

  logic             accept;
  logic [1:0]       req_bits;
  logic [LEN_W-1:0] req_len;
  logic             req_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size_log2      <= 5'd8;
      page_size_log2        <= 3'd3;
      two_byte_word_address <= 1'b0;
      base_device_address   <= 8'd160;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MEM_SIZE_LOG2:  memory_size_log2      <= cfg_data[4:0];
        REG_PAGE_SIZE_LOG2: page_size_log2        <= cfg_data[2:0];
        REG_TWO_BYTE_ADDR:  two_byte_word_address <= cfg_data[0];
        REG_BASE_DEV_ADDR:  base_device_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept    = start && (state == ST_IDLE);
  assign req_bits  = bank_bits(memory_size_log2, two_byte_word_address);
  assign req_len   = sat_length(request.length);
  // a read on an unbanked chip always gives one beat, even at length zero
  assign req_empty = (req_len == '0) &&
                     ((request.operation == OP_WRITE) || (req_bits != 2'd0));

  assign step_in.addr  = addr;
  assign step_in.done  = done;
  assign step_in.len   = len;
  assign step_in.mask  = mask;
  assign step_in.whole = whole;

  ets_step u_step (
    .op  (step_in),
    .res (step_out)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !req_empty) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (step_out.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr  <= request.start_address;
      done  <= '0;
      len   <= req_len;
      bits  <= req_bits;
      whole <= (request.operation == OP_READ) && (req_bits == 2'd0);
      mask  <= (request.operation == OP_WRITE) ? page_mask(page_size_log2) : 8'hFF;
    end else if (state == ST_RUN) begin
      addr <= step_out.addr_next;
      done <= step_out.done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      result.device_address <= device_byte(base_device_address, bits, addr);
      result.word_address   <= (bits != 2'd0) ? {8'd0, addr[7:0]} : addr;
      result.byte_count     <= step_out.cnt;
      result.buffer_offset  <= done[7:0];
      result.last_segment   <= step_out.last;
    end
  end

  assign busy = (state == ST_RUN);

  `ETS_ASSERT_SAME(a_last_frees, strobe && result.last_segment, !busy)
  `ETS_ASSERT_SAME(a_mid_busy, strobe && !result.last_segment, busy)
  `ETS_ASSERT_NEXT(a_run_emits, busy, strobe)
  `ETS_ASSERT_NEXT(a_mid_follows, strobe && !result.last_segment, strobe)

endmodule

@@ test/eeprom_transfer_segmenter_unit_test.sv @@
// Self-checking testbench of the EEPROM transfer segmenter: requests in, predicted segments out
module eeprom_transfer_segmenter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ets_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  ets_req_t   request = '0;
  logic       busy;
  logic       strobe;
  ets_res_t   result;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_MEM_SIZE_LOG2;
  logic [7:0] cfg_data = '0;

  // chip setting as the block should hold it
  logic [4:0] chip_mem_log2 = 5'd8;
  logic [2:0] chip_page_log2 = 3'd3;
  logic       chip_two_byte = 1'b0;
  logic [7:0] chip_base = 8'd160;

  ets_req_t    request_backlog[$];
  ets_res_t    expected_segments[$];
  ets_res_t    due_seg;
  int unsigned unsent_count = 0;
  int unsigned idle_left = 0;
  int unsigned mismatch_count = 0;
  logic        calm = 1'b0;

  eeprom_transfer_segmenter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .strobe    (strobe),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // work out the segments of one request under the current chip setting
  function automatic void split_request(input ets_req_t req);
    int unsigned cap, bits, span, len, done, addr, cnt, off;
    logic [2:0]  lowmask;
    ets_res_t    seg;
    cap = chip_mem_log2;
    if (cap < 7) cap = 7;
    if (cap > 16) cap = 16;
    bits = (chip_two_byte || cap <= 8) ? 0 : ((cap - 8 > 3) ? 3 : cap - 8);
    len = (req.length > MAX_LENGTH) ? MAX_LENGTH : req.length;
    addr = req.start_address;
    done = 0;
    if (req.operation == OP_READ && bits == 0) begin
      seg.device_address = chip_base;
      seg.word_address   = req.start_address;
      seg.byte_count     = 9'(len);
      seg.buffer_offset  = 8'd0;
      seg.last_segment   = 1'b1;
      expected_segments.push_back(seg);
    end else begin
      span = (req.operation == OP_READ) ? 256 :
             (1 << ((chip_page_log2 < 3'd3) ? 3 : chip_page_log2));
      lowmask = 3'((1 << bits) - 1);
      while (done < len) begin
        off = addr % span;
        cnt = (len - done < span - off) ? len - done : span - off;
        seg.device_address = (chip_base & ~{4'd0, lowmask, 1'b0}) |
                             {4'd0, 3'(addr >> 8) & lowmask, 1'b0};
        seg.word_address   = (bits != 0) ? 16'(addr & 'hFF) : 16'(addr);
        seg.byte_count     = 9'(cnt);
        seg.buffer_offset  = 8'(done);
        seg.last_segment   = (done + cnt >= len);
        expected_segments.push_back(seg);
        done += cnt;
        addr = (addr + cnt) & 'hFFFF;
      end
    end
  endfunction

  // driver: hold start until the request is taken, then maybe idle for a burst
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        split_request(request);
        unsent_count--;
      end
      if (start && busy) begin
      end else if (idle_left != 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        request <= request_backlog.pop_front();
        start <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 13);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_segments.size() == 0) begin
        flag_mismatch("segment with none expected");
      end else begin
        due_seg = expected_segments.pop_front();
        if (result.device_address !== due_seg.device_address)
          flag_mismatch($sformatf("device_address %h, want %h",
                                  result.device_address, due_seg.device_address));
        if (result.word_address !== due_seg.word_address)
          flag_mismatch($sformatf("word_address %h, want %h",
                                  result.word_address, due_seg.word_address));
        if (result.byte_count !== due_seg.byte_count)
          flag_mismatch($sformatf("byte_count %0d, want %0d",
                                  result.byte_count, due_seg.byte_count));
        if (result.buffer_offset !== due_seg.buffer_offset)
          flag_mismatch($sformatf("buffer_offset %0d, want %0d",
                                  result.buffer_offset, due_seg.buffer_offset));
        if (result.last_segment !== due_seg.last_segment)
          flag_mismatch($sformatf("last_segment %b, want %b",
                                  result.last_segment, due_seg.last_segment));
      end
    end
  end

  task automatic queue_request(input logic op, input logic [15:0] addr, input logic [8:0] len);
    ets_req_t req;
    req.operation     = op;
    req.start_address = addr;
    req.length        = len;
    request_backlog.push_back(req);
    unsent_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // unused upper data bits carry noise
  task automatic set_chip(input logic [4:0] mem, input logic [2:0] page,
                          input logic two, input logic [7:0] base);
    write_reg(REG_MEM_SIZE_LOG2, {3'($urandom), mem});
    write_reg(REG_PAGE_SIZE_LOG2, {5'($urandom), page});
    write_reg(REG_TWO_BYTE_ADDR, {7'($urandom), two});
    write_reg(REG_BASE_DEV_ADDR, base);
    @(posedge clk);
    cfg_write <= 1'b0;
    chip_mem_log2  = mem;
    chip_page_log2 = page;
    chip_two_byte  = two;
    chip_base      = base;
  endtask

  // wait for every request to be taken and every segment to arrive, then let the block idle
  task automatic settle();
    int unsigned waited;
    waited = 0;
    do @(posedge clk); while (unsent_count != 0 || busy);
    while (expected_segments.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (expected_segments.size() != 0) begin
      flag_mismatch($sformatf("%0d segments never arrived", expected_segments.size()));
      expected_segments.delete();
    end
  endtask

  initial begin : stimulus
    logic [15:0] addr;
    logic [8:0]  len;
    int unsigned pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset setting: 256-byte chip, 8-byte pages, unbanked
    queue_request(OP_READ, 16'h0000, 9'd0);
    queue_request(OP_WRITE, 16'h0000, 9'd0);
    queue_request(OP_WRITE, 16'h0000, 9'd256);
    queue_request(OP_WRITE, 16'h0003, 9'd256);
    queue_request(OP_WRITE, 16'hFFFC, 9'd10);
    queue_request(OP_READ, 16'hFFFF, 9'd511);
    queue_request(OP_WRITE, 16'h1234, 9'd300);
    queue_request(OP_READ, 16'h00FF, 9'd1);
    settle();

    // banked, capacity at top, page below minimum
    set_chip(5'd16, 3'd0, 1'b0, 8'hFF);
    queue_request(OP_READ, 16'h0000, 9'd0);
    queue_request(OP_READ, 16'h07F0, 9'd256);
    queue_request(OP_READ, 16'hFFF0, 9'd100);
    queue_request(OP_WRITE, 16'h0AFE, 9'd20);
    queue_request(OP_READ, 16'h0100, 9'd256);
    queue_request(OP_WRITE, 16'hFFFF, 9'd1);
    queue_request(OP_READ, 16'h0555, 9'd257);
    queue_request(OP_WRITE, 16'h0000, 9'd0);
    settle();

    // capacity above range, two-byte addressing, largest page
    set_chip(5'd31, 3'd7, 1'b1, 8'h00);
    queue_request(OP_WRITE, 16'h00FF, 9'd256);
    queue_request(OP_READ, 16'hFF00, 9'd256);
    queue_request(OP_WRITE, 16'h8000, 9'd511);
    queue_request(OP_READ, 16'h0000, 9'd0);
    settle();

    // capacity below range
    set_chip(5'd0, 3'd7, 1'b0, 8'h55);
    queue_request(OP_READ, 16'h01FF, 9'd256);
    queue_request(OP_WRITE, 16'h007F, 9'd2);
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_chip(5'd9, 3'd1, 1'b0, 8'hAA);
        1: set_chip(5'd10, 3'd2, 1'b0, 8'h00);
        2: set_chip(5'd11, 3'd5, 1'b0, 8'h0E);
        3: set_chip(5'd12, 3'd6, 1'b1, 8'hFF);
        default: set_chip($urandom_range(0, 1) ? 5'($urandom_range(7, 16)) : 5'($urandom),
                          3'($urandom), 1'($urandom), 8'($urandom));
      endcase
      calm = (p == 9);
      repeat (30) begin
        addr = 16'($urandom);
        if ($urandom_range(0, 2) == 0) addr[7:0] = 8'hFF - 8'($urandom_range(0, 15));
        pick = $urandom_range(0, 19);
        if (pick < 10) len = 9'($urandom_range(0, 40));
        else if (pick < 16) len = 9'($urandom_range(0, 256));
        else if (pick < 18) len = 9'd256;
        else len = 9'($urandom_range(257, 511));
        queue_request($urandom_range(0, 1) ? OP_WRITE : OP_READ, addr, len);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
